/* rtl/core/multitouch_to_single_touch_top_assert.svh */
// Assertion macros shared by the multitouch-to-single-touch RTL.
// Needs clk and rst_n in the scope of each use; empty bodies when SYNTH is set.
`ifndef MULTITOUCH_TO_SINGLE_TOUCH_TOP_ASSERT_SVH
`define MULTITOUCH_TO_SINGLE_TOUCH_TOP_ASSERT_SVH
`ifndef SYNTH
`define MTST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mtst assertion failed");
`define MTST_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtst implication failed");
`else
`define MTST_ASSERT(lbl, prop)
`define MTST_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

/* rtl/core/mtst_pkg.sv */
// Package for the multitouch-to-single-touch block: widths, event codes,
// register map, reset values and shared structs. No dependencies.
`default_nettype none
package mtst_pkg;

  localparam int TYPE_W = 5;
  localparam int CODE_W = 10;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 32;
  localparam int KIND_W = 2;
  localparam int PAN_W  = 16;
  localparam int SCR_W  = 14;
  localparam int ROT_W  = 2;
  localparam int OPD_W  = POS_W + 2;
  localparam int PROD_W = PAN_W + SCR_W;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int IDX_W  = ADDR_W - 2;

  localparam logic [TYPE_W-1:0] EVT_SYN = 5'd0;
  localparam logic [TYPE_W-1:0] EVT_KEY = 5'd1;
  localparam logic [TYPE_W-1:0] EVT_ABS = 5'd3;

  localparam logic [CODE_W-1:0] CODE_SYN_REPORT = 10'h000;
  localparam logic [CODE_W-1:0] CODE_SLOT       = 10'h02f;
  localparam logic [CODE_W-1:0] CODE_POS_X      = 10'h035;
  localparam logic [CODE_W-1:0] CODE_POS_Y      = 10'h036;
  localparam logic [CODE_W-1:0] CODE_TRACK      = 10'h039;
  localparam logic [CODE_W-1:0] CODE_BTN_TOUCH  = 10'h14a;

  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UP   = 2'd2;

  localparam logic [ROT_W-1:0] ROT_NONE    = 2'd0;
  localparam logic [ROT_W-1:0] ROT_SWAP_MY = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180     = 2'd2;
  localparam logic [ROT_W-1:0] ROT_SWAP_MX = 2'd3;

  localparam logic [IDX_W-1:0] REG_PMAX_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_PMAX_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_SCR_W  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SCR_H  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROT    = 3'd4;
  localparam logic [IDX_W-1:0] REG_XF_EN  = 3'd5;

  localparam logic [PAN_W-1:0] RST_PMAX_X = 16'd1448;
  localparam logic [PAN_W-1:0] RST_PMAX_Y = 16'd1072;
  localparam logic [SCR_W-1:0] RST_SCR_W  = 14'd1072;
  localparam logic [SCR_W-1:0] RST_SCR_H  = 14'd1448;
  localparam logic [ROT_W-1:0] RST_ROT    = ROT_SWAP_MY;

  typedef struct packed {
    logic [PAN_W-1:0] pmax_x;
    logic [PAN_W-1:0] pmax_y;
    logic [SCR_W-1:0] scr_w;
    logic [SCR_W-1:0] scr_h;
    logic [ROT_W-1:0] rot;
    logic             xf_en;
  } mtst_cfg_t;

  typedef struct packed {
    logic              emit;
    logic [KIND_W-1:0] kind;
  } mtst_evt_t;

endpackage
`default_nettype wire

/* rtl/core/mtst_regs.sv */
// APB-style configuration register file for the touch converter.
// Depends on mtst_pkg.
`default_nettype none
module mtst_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtst_pkg::ADDR_W-1:0] paddr,
  input  logic [mtst_pkg::DATA_W-1:0] pwdata,
  output logic [mtst_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output mtst_pkg::mtst_cfg_t         cfg
);
  import mtst_pkg::*;

  mtst_cfg_t        cfg_r;
  logic [IDX_W-1:0] idx;
  logic             wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pmax_x <= RST_PMAX_X;
      cfg_r.pmax_y <= RST_PMAX_Y;
      cfg_r.scr_w  <= RST_SCR_W;
      cfg_r.scr_h  <= RST_SCR_H;
      cfg_r.rot    <= RST_ROT;
      cfg_r.xf_en  <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_PMAX_X: cfg_r.pmax_x <= pwdata[PAN_W-1:0];
        REG_PMAX_Y: cfg_r.pmax_y <= pwdata[PAN_W-1:0];
        REG_SCR_W:  cfg_r.scr_w  <= pwdata[SCR_W-1:0];
        REG_SCR_H:  cfg_r.scr_h  <= pwdata[SCR_W-1:0];
        REG_ROT:    cfg_r.rot    <= pwdata[ROT_W-1:0];
        REG_XF_EN:  cfg_r.xf_en  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PMAX_X: prdata = DATA_W'(cfg_r.pmax_x);
      REG_PMAX_Y: prdata = DATA_W'(cfg_r.pmax_y);
      REG_SCR_W:  prdata = DATA_W'(cfg_r.scr_w);
      REG_SCR_H:  prdata = DATA_W'(cfg_r.scr_h);
      REG_ROT:    prdata = DATA_W'(cfg_r.rot);
      REG_XF_EN:  prdata = DATA_W'(cfg_r.xf_en);
      default:    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/mtst_slot_tbl.sv */
// Contact slot table and event decoder: slot flags, positions, current slot
// and touch state; flags which transaction reports. Depends on mtst_pkg.
`default_nettype none
`include "multitouch_to_single_touch_top_assert.svh"
module mtst_slot_tbl #(
  parameter int NUM_SLOTS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  logic [mtst_pkg::TYPE_W-1:0] ev_type,
  input  logic [mtst_pkg::CODE_W-1:0] ev_code,
  input  logic [mtst_pkg::VAL_W-1:0]  ev_value,
  output mtst_pkg::mtst_evt_t         evt,
  output logic [mtst_pkg::POS_W-1:0]  emit_x,
  output logic [mtst_pkg::POS_W-1:0]  emit_y
);
  import mtst_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [NUM_SLOTS-1:0] act_r, act_nxt;
  logic [NUM_SLOTS-1:0] idv_r, idv_nxt;
  logic [POS_W-1:0]     x_r [NUM_SLOTS];
  logic [POS_W-1:0]     y_r [NUM_SLOTS];
  logic [SLOT_W-1:0]    cur_r, cur_nxt;
  logic                 touch_r, touch_nxt;

  logic [SLOT_W-1:0] esel;
  logic [SLOT_W-1:0] a_idx, av_idx;
  logic              a_hit, av_hit;
  logic              slot_ok, rel, wr_x, wr_y;

  // lowest active slot, and lowest active slot with a valid id
  always_comb begin
    a_hit  = 1'b0;
    av_hit = 1'b0;
    a_idx  = '0;
    av_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (act_r[i]) begin
        a_hit = 1'b1;
        a_idx = SLOT_W'(i);
      end
      if (act_r[i] && idv_r[i]) begin
        av_hit = 1'b1;
        av_idx = SLOT_W'(i);
      end
    end
  end

  assign slot_ok = !ev_value[VAL_W-1] && (ev_value < VAL_W'(NUM_SLOTS));
  assign rel     = (ev_value == '1);
  assign wr_x    = acc && (ev_type == EVT_ABS) && (ev_code == CODE_POS_X);
  assign wr_y    = acc && (ev_type == EVT_ABS) && (ev_code == CODE_POS_Y);

  always_comb begin
    act_nxt   = act_r;
    idv_nxt   = idv_r;
    cur_nxt   = cur_r;
    touch_nxt = touch_r;
    esel      = cur_r;
    evt       = '0;
    case (ev_type)
      EVT_ABS: begin
        case (ev_code)
          CODE_SLOT: begin
            if (slot_ok) cur_nxt = ev_value[SLOT_W-1:0];
          end
          CODE_TRACK: begin
            act_nxt[cur_r] = ~rel;
            idv_nxt[cur_r] = ~ev_value[VAL_W-1];
            // lift of an active slot, or a fresh contact while touching
            if (touch_r && (rel == act_r[cur_r])) begin
              touch_nxt = 1'b0;
              evt.emit  = 1'b1;
              evt.kind  = KIND_UP;
            end
          end
          default: ;
        endcase
      end
      EVT_KEY: begin
        if (ev_code == CODE_BTN_TOUCH && ev_value == '0) begin
          touch_nxt = 1'b0;
          esel      = a_idx;
          if (a_hit) begin
            act_nxt[a_idx] = 1'b0;
            idv_nxt[a_idx] = 1'b0;
            evt.emit       = touch_r;
            evt.kind       = KIND_UP;
          end
        end
      end
      EVT_SYN: begin
        if (ev_code == CODE_SYN_REPORT && av_hit) begin
          esel      = av_idx;
          touch_nxt = 1'b1;
          evt.emit  = 1'b1;
          evt.kind  = touch_r ? KIND_MOVE : KIND_DOWN;
        end
      end
      default: ;
    endcase
  end

  assign emit_x = x_r[esel];
  assign emit_y = y_r[esel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= '0;
      idv_r   <= '0;
      cur_r   <= '0;
      touch_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        x_r[i] <= '0;
        y_r[i] <= '0;
      end
    end else begin
      if (acc) begin
        act_r   <= act_nxt;
        idv_r   <= idv_nxt;
        cur_r   <= cur_nxt;
        touch_r <= touch_nxt;
      end
      if (wr_x) x_r[cur_r] <= ev_value;
      if (wr_y) y_r[cur_r] <= ev_value;
    end
  end

  `MTST_ASSERT(a_touch_has_contact, touch_r |-> (act_r != '0))
  `MTST_ASSERT(a_idv_only_active, ((idv_r & ~act_r) == '0))
  `MTST_ASSERT(a_cur_in_range, ({1'b0, cur_r} < (SLOT_W + 1)'(NUM_SLOTS)))

endmodule
`default_nettype wire

/* rtl/core/mtst_scaler.sv */
// Shared coordinate scaler: clamp checks, one registered multiply, then a
// 14-step restoring divide (one compare/subtract per cycle). Depends on mtst_pkg.
`default_nettype none
`include "multitouch_to_single_touch_top_assert.svh"
module mtst_scaler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [mtst_pkg::OPD_W-1:0]  opd,
  input  logic        [mtst_pkg::PAN_W-1:0]  rng,
  input  logic        [mtst_pkg::SCR_W-1:0]  sz,
  output logic                               done,
  output logic        [mtst_pkg::SCR_W-1:0]  q
);
  import mtst_pkg::*;

  localparam int CNT_W = $clog2(SCR_W);
  localparam logic SC_IDLE = 1'b0;
  localparam logic SC_DIV  = 1'b1;

  logic              st_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PROD_W-1:0] rem_r, dvs_r;
  logic [SCR_W-1:0]  q_r, sz_r;
  logic              done_r;
  logic              ge;
  logic [PROD_W-1:0] diff;

  assign ge   = (rem_r >= dvs_r);
  assign diff = rem_r - dvs_r;
  assign done = done_r;
  assign q    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SC_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        SC_IDLE: begin
          if (start) begin
            sz_r <= sz;
            if (opd[OPD_W-1] || opd == '0) begin
              q_r    <= '0;
              done_r <= 1'b1;
            end else if (opd >= $signed(OPD_W'(rng))) begin
              q_r    <= sz - SCR_W'(1);
              done_r <= 1'b1;
            end else begin
              // here 0 < opd < rng, so the quotient stays below sz
              rem_r <= PROD_W'(opd[PAN_W-1:0]) * PROD_W'(sz);
              dvs_r <= PROD_W'({rng, {(SCR_W - 1){1'b0}}});
              q_r   <= '0;
              cnt_r <= '0;
              st_r  <= SC_DIV;
            end
          end
        end
        SC_DIV: begin
          if (ge) rem_r <= diff;
          q_r   <= {q_r[SCR_W-2:0], ge};
          dvs_r <= dvs_r >> 1;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(SCR_W - 1)) begin
            st_r   <= SC_IDLE;
            done_r <= 1'b1;
          end
        end
        default: st_r <= SC_IDLE;
      endcase
    end
  end

  `MTST_ASSERT_IMPL(a_q_clamped, done_r, (q_r < sz_r))
  `MTST_ASSERT_IMPL(a_start_idle, start, (st_r == SC_IDLE))
  `MTST_ASSERT_IMPL(a_no_done_in_div, (st_r == SC_DIV), !done_r)

endmodule
`default_nettype wire

/* rtl/core/multitouch_to_single_touch_top.sv */
// A transaction with no report leaves the block idle; a report goes via S_PUSH to
// out_valid raw, or via S_XS, S_XW, S_YS, S_YW and S_PUSH with the transform on (two
// 14-step divides run back to back on the one shared scaler). in_stall holds off new
// input until the report is loaded, and longer while out_stall holds.
// Reset (rst_n, synchronous): slot table, touch state and registers to defaults.
// Top level; uses mtst_pkg, mtst_regs, mtst_slot_tbl, mtst_scaler.
`default_nettype none
`include "multitouch_to_single_touch_top_assert.svh"
module multitouch_to_single_touch_top #(
  parameter int NUM_SLOTS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic        [mtst_pkg::TYPE_W-1:0] in_event_type,
  input  logic        [mtst_pkg::CODE_W-1:0] in_event_code,
  input  logic signed [mtst_pkg::VAL_W-1:0]  in_event_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [mtst_pkg::KIND_W-1:0] out_touch_kind,
  output logic signed [mtst_pkg::POS_W-1:0]  out_pos_x,
  output logic signed [mtst_pkg::POS_W-1:0]  out_pos_y,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic        [mtst_pkg::ADDR_W-1:0] paddr,
  input  logic        [mtst_pkg::DATA_W-1:0] pwdata,
  output logic        [mtst_pkg::DATA_W-1:0] prdata,
  output logic                               pready
);
  import mtst_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_XS   = 3'd1;
  localparam logic [2:0] S_XW   = 3'd2;
  localparam logic [2:0] S_YS   = 3'd3;
  localparam logic [2:0] S_YW   = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  mtst_cfg_t  cfg;
  mtst_evt_t  evt;
  logic [POS_W-1:0] emit_x, emit_y;

  logic [2:0]        state_r, state_nxt;
  logic [KIND_W-1:0] kind_r;
  logic [POS_W-1:0]  rx_r, ry_r, ox_r, oy_r;
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [POS_W-1:0]  out_x_r, out_y_r;

  logic acc, xform_on, load;
  logic sc_start, sc_done;
  logic [SCR_W-1:0] sc_q;
  logic signed [OPD_W-1:0] sx, sy, mx_m_x, my_m_y, opd_x, opd_y, sc_opd;
  logic [PAN_W-1:0] rng_x, rng_y, sc_rng;
  logic [SCR_W-1:0] sc_sz;

  mtst_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mtst_slot_tbl #(.NUM_SLOTS(NUM_SLOTS)) u_slot_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .ev_type  (in_event_type),
    .ev_code  (in_event_code),
    .ev_value (in_event_value),
    .evt      (evt),
    .emit_x   (emit_x),
    .emit_y   (emit_y)
  );

  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign xform_on = cfg.xf_en && (cfg.pmax_x != '0) && (cfg.pmax_y != '0)
                    && (cfg.scr_w != '0) && (cfg.scr_h != '0);

  // rotation operands
  assign sx     = {{(OPD_W - POS_W){rx_r[POS_W-1]}}, rx_r};
  assign sy     = {{(OPD_W - POS_W){ry_r[POS_W-1]}}, ry_r};
  assign mx_m_x = $signed(OPD_W'(cfg.pmax_x)) - sx;
  assign my_m_y = $signed(OPD_W'(cfg.pmax_y)) - sy;

  always_comb begin
    case (cfg.rot)
      ROT_NONE: begin
        opd_x = sx;     rng_x = cfg.pmax_x;
        opd_y = sy;     rng_y = cfg.pmax_y;
      end
      ROT_SWAP_MY: begin
        opd_x = my_m_y; rng_x = cfg.pmax_y;
        opd_y = sx;     rng_y = cfg.pmax_x;
      end
      ROT_180: begin
        opd_x = mx_m_x; rng_x = cfg.pmax_x;
        opd_y = my_m_y; rng_y = cfg.pmax_y;
      end
      default: begin
        opd_x = sy;     rng_x = cfg.pmax_y;
        opd_y = mx_m_x; rng_y = cfg.pmax_x;
      end
    endcase
  end

  assign sc_start = (state_r == S_XS) || (state_r == S_YS);
  assign sc_opd   = (state_r == S_YS) ? opd_y : opd_x;
  assign sc_rng   = (state_r == S_YS) ? rng_y : rng_x;
  assign sc_sz    = (state_r == S_YS) ? cfg.scr_h : cfg.scr_w;

  mtst_scaler u_scaler (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sc_start),
    .opd   (sc_opd),
    .rng   (sc_rng),
    .sz    (sc_sz),
    .done  (sc_done),
    .q     (sc_q)
  );

  assign load = (state_r == S_PUSH) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (acc && evt.emit) state_nxt = xform_on ? S_XS : S_PUSH;
      S_XS:   state_nxt = S_XW;
      S_XW:   if (sc_done) state_nxt = S_YS;
      S_YS:   state_nxt = S_YW;
      S_YW:   if (sc_done) state_nxt = S_PUSH;
      S_PUSH: if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && evt.emit) begin
      kind_r <= evt.kind;
      rx_r   <= emit_x;
      ry_r   <= emit_y;
      ox_r   <= emit_x;
      oy_r   <= emit_y;
    end
    if (state_r == S_XW && sc_done) ox_r <= POS_W'(sc_q);
    if (state_r == S_YW && sc_done) oy_r <= POS_W'(sc_q);
    if (load) begin
      out_kind_r <= kind_r;
      out_x_r    <= ox_r;
      out_y_r    <= oy_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_touch_kind = out_kind_r;
  assign out_pos_x      = out_x_r;
  assign out_pos_y      = out_y_r;

  `MTST_ASSERT(a_report_leaves_idle, (acc && evt.emit) |=> (state_r != S_IDLE))
  `MTST_ASSERT_IMPL(a_done_when_waiting, sc_done, (state_r == S_XW || state_r == S_YW))
  `MTST_ASSERT(a_push_fills_empty, (state_r == S_PUSH && !out_valid_r) |=> out_valid_r)

endmodule
`default_nettype wire
